// ----- rtl/stb_pkg.sv -----
// Shared constants, command and status types for the soft timer bank.
`timescale 1ns / 1ps

package stb_pkg;

  localparam int FUNC_W     = 4;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 31;
  localparam int CNT_W      = 32;
  localparam int EXT_W      = 9;   // wide enough for any slot index up to 256 timers
  localparam int TIMERS_DEF = 16;
  localparam int MAX_RES    = 16;

  localparam logic [FUNC_W-1:0] FN_TICK     = 4'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 4'd2;
  localparam logic [FUNC_W-1:0] FN_START    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_STOP     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_GET_TIME = 4'd5;
  localparam logic [FUNC_W-1:0] FN_SET_TIME = 4'd6;
  localparam logic [FUNC_W-1:0] FN_ONESHOT  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_PERIODIC = 4'd8;

  typedef struct packed {
    logic capture;      // latch the incoming word
    logic rd_en;        // read both count memories
    logic rd_op;        // read address comes from the latched slot
    logic apply_op;     // execute a single-slot operation and emit its word
    logic create_take;  // allocate the scanned slot and emit it
    logic create_fail;  // emit the no-free-slot word
    logic tick_upd;     // update the slot in the tick update stage
    logic hold_fire;    // keep the firing slot as the pending word
    logic push_held;    // emit the pending fire, not last
    logic end_held;     // emit the pending fire as last
    logic end_plain;    // emit a plain last word
  } stb_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic op_create;
    logic slot_free;
    logic b_fire;
    logic out_free;
  } stb_sts_t;

  // zero or negative in two's complement
  function automatic logic not_positive(input logic [CNT_W-1:0] v);
    not_positive = (v == '0) || v[CNT_W-1];
  endfunction

endpackage

// ----- rtl/stb_in_if.sv -----
// Request channel of the soft timer bank.
`timescale 1ns / 1ps

interface stb_in_if;
  logic                           valid;
  logic                           ready;
  logic [stb_pkg::FUNC_W-1:0]     func;
  logic [stb_pkg::SLOT_W-1:0]     slot;
  logic [stb_pkg::TIME_W-1:0]     time_value;
  logic                           periodic_mode;

  modport source (output valid, func, slot, time_value, periodic_mode, input ready);
  modport sink   (input valid, func, slot, time_value, periodic_mode, output ready);
endinterface

// ----- rtl/stb_out_if.sv -----
// Result channel of the soft timer bank.
`timescale 1ns / 1ps

interface stb_out_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic                              fired;
  logic [stb_pkg::SLOT_W-1:0]        result_slot;
  logic signed [stb_pkg::CNT_W-1:0]  remaining;
  logic                              last;

  modport source (output valid, status, fired, result_slot, remaining, last, input ready);
  modport sink   (input valid, status, fired, result_slot, remaining, last, output ready);
endinterface

// ----- rtl/soft_timer_bank_unit.sv -----
// Top level of the soft timer bank: controller plus datapath.
// Usage:
//   in_ch carries one request word: func, slot, time_value, periodic_mode.
//   out_ch returns result words: status, fired, result_slot, remaining, last.
//   Every request yields one or more result words; the final one has last set.
//   A request is taken only while the bank is idle; one request is in work
//   at a time, but a finished word may still sit in the output register.
// Sequence:
//   Single-slot operations latch the request, read the slot, then apply it and
//   register the result once the output register is free. Create scans one
//   slot per cycle for the first free slot. Tick walks all slots through a
//   two-stage read/update pipeline, one slot per cycle unless a new fire meets
//   a held fire word and a full output register. At most 16 fires are reported.
//   The next request is taken the cycle after the last word is registered.
// Reset:
//   rst_n clears all timers; the count memory reads as zero until written.
// Stall:
//   When out_ch.ready is low the result word holds and the bank waits at the
//   point where it must emit another word.
`timescale 1ns / 1ps

module soft_timer_bank_unit #(
  parameter int TIMERS = stb_pkg::TIMERS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch
);

  localparam int IDXW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  stb_pkg::stb_cmd_t cmd;
  stb_pkg::stb_sts_t sts;
  logic [IDXW-1:0]   scan_idx, b_idx;
  logic              ctl_ready;

  assign in_ch.ready = ctl_ready;

  stb_ctrl #(.TIMERS(TIMERS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd),
    .scan_idx (scan_idx),
    .b_idx    (b_idx)
  );

  stb_datapath #(.TIMERS(TIMERS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .scan_idx         (scan_idx),
    .b_idx            (b_idx),
    .sts              (sts),
    .in_func          (in_ch.func),
    .in_slot          (in_ch.slot),
    .in_time_value    (in_ch.time_value),
    .in_periodic_mode (in_ch.periodic_mode),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_fired        (out_ch.fired),
    .out_result_slot  (out_ch.result_slot),
    .out_remaining    (out_ch.remaining),
    .out_last         (out_ch.last)
  );

endmodule

// ----- rtl/stb_ctrl.sv -----
// Controller: operation sequencing, slot scan and fire reporting.
`timescale 1ns / 1ps

module stb_ctrl #(
  parameter int TIMERS = stb_pkg::TIMERS_DEF,
  localparam int IDXW  = (TIMERS > 1) ? $clog2(TIMERS) : 1,
  localparam int CNTW  = $clog2(TIMERS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stb_pkg::stb_sts_t sts,
  output stb_pkg::stb_cmd_t cmd,
  output logic [IDXW-1:0]   scan_idx,
  output logic [IDXW-1:0]   b_idx
);

  localparam int NW = $clog2(stb_pkg::MAX_RES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OP     = 3'd1;
  localparam logic [2:0] ST_APPLY  = 3'd2;
  localparam logic [2:0] ST_CREATE = 3'd3;
  localparam logic [2:0] ST_TICK   = 3'd4;
  localparam logic [2:0] ST_TEND   = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] scan_r, scan_nxt;
  logic            b_valid_r, b_valid_nxt;
  logic [IDXW-1:0] b_idx_r, b_idx_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic            held_v_r, held_v_nxt;

  logic report, stall, issue;

  assign scan_idx = scan_r[IDXW-1:0];
  assign b_idx    = b_idx_r;
  assign in_ready = (state_r == ST_IDLE);

  assign report = b_valid_r && sts.b_fire && (n_r < NW'(stb_pkg::MAX_RES));
  assign stall  = report && held_v_r && !sts.out_free;
  assign issue  = (scan_r < CNTW'(TIMERS));

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    b_valid_nxt = b_valid_r;
    b_idx_nxt   = b_idx_r;
    n_nxt       = n_r;
    held_v_nxt  = held_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_OP;
        end
      end
      ST_OP: begin
        scan_nxt = '0;
        if (sts.op_tick) begin
          b_valid_nxt = 1'b0;
          n_nxt       = '0;
          held_v_nxt  = 1'b0;
          state_nxt   = ST_TICK;
        end else if (sts.op_create) begin
          state_nxt = ST_CREATE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_op = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          cmd.apply_op = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CREATE: begin
        if (sts.slot_free) begin
          if (sts.out_free) begin
            cmd.create_take = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (scan_r == CNTW'(TIMERS - 1)) begin
          if (sts.out_free) begin
            cmd.create_fail = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_TICK: begin
        if (!stall) begin
          cmd.tick_upd = b_valid_r;
          if (report) begin
            // the previous fire is not last: send it before keeping this one
            cmd.push_held = held_v_r;
            cmd.hold_fire = 1'b1;
            held_v_nxt    = 1'b1;
            n_nxt         = n_r + 1'b1;
          end
          cmd.rd_en   = issue;
          b_valid_nxt = issue;
          b_idx_nxt   = scan_r[IDXW-1:0];
          if (issue) begin
            scan_nxt = scan_r + 1'b1;
          end else if (!b_valid_r) begin
            state_nxt = ST_TEND;
          end
        end
      end
      ST_TEND: begin
        if (sts.out_free) begin
          cmd.end_held  = held_v_r;
          cmd.end_plain = !held_v_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      scan_r    <= '0;
      b_valid_r <= 1'b0;
      b_idx_r   <= '0;
      n_r       <= '0;
      held_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_r    <= scan_nxt;
      b_valid_r <= b_valid_nxt;
      b_idx_r   <= b_idx_nxt;
      n_r       <= n_nxt;
      held_v_r  <= held_v_nxt;
    end
  end

endmodule

// ----- rtl/stb_datapath.sv -----
// Datapath: timer flags, count memories, tick update and result register.
`timescale 1ns / 1ps

module stb_datapath #(
  parameter int TIMERS = stb_pkg::TIMERS_DEF,
  localparam int IDXW  = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stb_pkg::stb_cmd_t                 cmd,
  input  logic [IDXW-1:0]                   scan_idx,
  input  logic [IDXW-1:0]                   b_idx,
  output stb_pkg::stb_sts_t                 sts,
  input  logic [stb_pkg::FUNC_W-1:0]        in_func,
  input  logic [stb_pkg::SLOT_W-1:0]        in_slot,
  input  logic [stb_pkg::TIME_W-1:0]        in_time_value,
  input  logic                              in_periodic_mode,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_status,
  output logic                              out_fired,
  output logic [stb_pkg::SLOT_W-1:0]        out_result_slot,
  output logic signed [stb_pkg::CNT_W-1:0]  out_remaining,
  output logic                              out_last
);

  localparam int CW = stb_pkg::CNT_W;
  localparam int TW = stb_pkg::TIME_W;
  localparam int EW = stb_pkg::EXT_W;

  // latched request
  logic [stb_pkg::FUNC_W-1:0] op_func_r;
  logic [stb_pkg::SLOT_W-1:0] op_slot_r;
  logic [TW-1:0]              op_tv_r;
  logic                       op_pm_r;

  logic [TIMERS-1:0] occ_r, act_r, per_r;
  logic [TIMERS-1:0] cnt_v_r;
  logic [CW-1:0]     cnt_mem [TIMERS];
  logic [TW-1:0]     rel_mem [TIMERS];

  logic [CW-1:0]   rd_cnt_r;
  logic [TW-1:0]   rd_rel_r;
  logic            rd_cnt_ok_r;
  logic [IDXW-1:0] held_r;

  logic                       out_valid_r, out_status_r, out_fired_r, out_last_r;
  logic [stb_pkg::SLOT_W-1:0] out_slot_r;
  logic [CW-1:0]              out_rem_r;

  logic [EW-1:0]   op_ext, scan_ext, held_ext;
  logic            op_inr;
  logic [IDXW-1:0] op_idx, rd_addr;
  logic [CW-1:0]   cnt_val, b_dec;
  logic [TW-1:0]   rel_val;
  logic            b_live, b_fire;
  logic            cw_en, rw_en;
  logic [IDXW-1:0] cw_addr, rw_addr;
  logic [CW-1:0]   cw_data;
  logic [TW-1:0]   rw_data;
  logic            emit;

  assign op_ext   = EW'(op_slot_r);
  assign op_inr   = (op_ext < EW'(TIMERS));
  assign op_idx   = op_ext[IDXW-1:0];
  assign scan_ext = EW'(scan_idx);
  assign held_ext = EW'(held_r);
  assign rd_addr  = cmd.rd_op ? op_idx : scan_idx;

  // never-written count entries read as zero; reload is used for occupied slots only
  assign cnt_val = rd_cnt_ok_r ? rd_cnt_r : '0;
  assign rel_val = rd_rel_r;

  assign b_dec  = cnt_val - 1'b1;
  assign b_live = occ_r[b_idx] && act_r[b_idx];
  assign b_fire = b_live && stb_pkg::not_positive(b_dec);

  assign sts.op_tick   = (op_func_r == stb_pkg::FN_TICK);
  assign sts.op_create = (op_func_r == stb_pkg::FN_CREATE);
  assign sts.slot_free = !occ_r[scan_idx];
  assign sts.b_fire    = b_fire;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func_r <= in_func;
      op_slot_r <= in_slot;
      op_tv_r   <= in_time_value;
      op_pm_r   <= in_periodic_mode;
    end
  end

  // memory write ports
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = b_idx;
    cw_data = b_dec;
    rw_en   = 1'b0;
    rw_addr = op_idx;
    rw_data = op_tv_r;
    if (cmd.tick_upd && b_live) begin
      cw_en = 1'b1;
      if (b_fire && per_r[b_idx]) begin
        cw_data = CW'(rel_val);
      end
    end else if (cmd.create_take) begin
      cw_en   = 1'b1;
      cw_addr = scan_idx;
      cw_data = CW'(op_tv_r);
      rw_en   = 1'b1;
      rw_addr = scan_idx;
    end else if (cmd.apply_op && op_inr) begin
      cw_addr = op_idx;
      if (op_func_r == stb_pkg::FN_DELETE) begin
        cw_en   = 1'b1;
        cw_data = '0;
        rw_en   = 1'b1;
        rw_data = '0;
      end else if (op_func_r == stb_pkg::FN_SET_TIME) begin
        cw_en   = 1'b1;
        cw_data = CW'(op_tv_r);
        rw_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cnt_mem[cw_addr] <= cw_data;
    end
    if (rw_en) begin
      rel_mem[rw_addr] <= rw_data;
    end
    if (cmd.rd_en) begin
      rd_cnt_r    <= cnt_mem[rd_addr];
      rd_rel_r    <= rel_mem[rd_addr];
      rd_cnt_ok_r <= cnt_v_r[rd_addr];
    end
    if (cmd.hold_fire) begin
      held_r <= b_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_v_r <= '0;
    end else begin
      if (cw_en) begin
        cnt_v_r[cw_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      act_r <= '0;
      per_r <= '0;
    end else begin
      if (cmd.tick_upd && b_fire && !per_r[b_idx]) begin
        act_r[b_idx] <= 1'b0;
      end
      if (cmd.create_take) begin
        occ_r[scan_idx] <= 1'b1;
        act_r[scan_idx] <= 1'b0;
        per_r[scan_idx] <= op_pm_r;
      end
      if (cmd.apply_op && op_inr) begin
        unique case (op_func_r)
          stb_pkg::FN_DELETE: begin
            occ_r[op_idx] <= 1'b0;
            act_r[op_idx] <= 1'b0;
            per_r[op_idx] <= 1'b0;
          end
          stb_pkg::FN_START: begin
            if (occ_r[op_idx]) act_r[op_idx] <= 1'b1;
          end
          stb_pkg::FN_STOP: begin
            if (occ_r[op_idx]) act_r[op_idx] <= 1'b0;
          end
          stb_pkg::FN_ONESHOT: begin
            per_r[op_idx] <= 1'b0;
          end
          stb_pkg::FN_PERIODIC: begin
            per_r[op_idx] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  assign emit = cmd.apply_op || cmd.create_take || cmd.create_fail ||
                cmd.push_held || cmd.end_held || cmd.end_plain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= cmd.create_fail;
      out_fired_r  <= cmd.push_held || cmd.end_held;
      out_last_r   <= !cmd.push_held;
      if (cmd.create_take) begin
        out_slot_r <= scan_ext[stb_pkg::SLOT_W-1:0];
      end else if (cmd.push_held || cmd.end_held) begin
        out_slot_r <= held_ext[stb_pkg::SLOT_W-1:0];
      end else begin
        out_slot_r <= '0;
      end
      if (cmd.apply_op && op_inr && (op_func_r == stb_pkg::FN_GET_TIME)) begin
        out_rem_r <= cnt_val;
      end else begin
        out_rem_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fired       = out_fired_r;
  assign out_result_slot = out_slot_r;
  assign out_remaining   = signed'(out_rem_r);
  assign out_last        = out_last_r;

endmodule

// ----- tb/sv/stb_result_checker.sv -----
// Result checker for the soft timer bank: predicts every result word and compares it.
`timescale 1ns / 1ps

module stb_result_checker (
  input  logic clk,
  input  logic rst_n,
  stb_in_if    req_mon,
  stb_out_if   res_mon,
  output int   fail_count,
  output int   pending_words
);
  import stb_pkg::*;

  localparam int TIMERS = TIMERS_DEF;

  typedef struct packed {
    logic              status;
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  remaining;
    logic              last;
  } timer_word_t;

  logic             slot_used    [TIMERS];
  logic             slot_running [TIMERS];
  logic             slot_repeat  [TIMERS];
  logic [CNT_W-1:0] reload_val   [TIMERS];
  logic [CNT_W-1:0] count_val    [TIMERS];

  timer_word_t expected_words[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic timer_word_t make_word(input logic st, input logic fi,
                                            input logic [SLOT_W-1:0] sl,
                                            input logic [CNT_W-1:0] rem, input logic la);
    timer_word_t w;
    w.status    = st;
    w.fired     = fi;
    w.slot      = sl;
    w.remaining = rem;
    w.last      = la;
    return w;
  endfunction

  // Apply one request word to the timer table and queue the words it yields.
  task automatic advance_bank(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] sl,
                              input logic [TIME_W-1:0] tv, input logic pm);
    int   fire_slots[$];
    logic found;
    logic get_done;
    found    = 1'b0;
    get_done = 1'b0;
    case (fn)
      FN_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (slot_used[i] && slot_running[i]) begin
            count_val[i] = count_val[i] - 1'b1;
            // zero or negative counts fire
            if (count_val[i] == '0 || count_val[i][CNT_W-1]) begin
              if (fire_slots.size() < MAX_RES) fire_slots.push_back(i);
              if (slot_repeat[i]) count_val[i] = reload_val[i];
              else slot_running[i] = 1'b0;
            end
          end
        end
        if (fire_slots.size() == 0) begin
          expected_words.push_back(make_word(1'b0, 1'b0, '0, '0, 1'b1));
        end else begin
          foreach (fire_slots[k]) begin
            expected_words.push_back(make_word(1'b0, 1'b1, SLOT_W'(fire_slots[k]), '0,
                                               k == fire_slots.size() - 1));
          end
        end
      end
      FN_CREATE: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (!found && !slot_used[i]) begin
            found           = 1'b1;
            slot_used[i]    = 1'b1;
            slot_running[i] = 1'b0;
            slot_repeat[i]  = pm;
            reload_val[i]   = {1'b0, tv};
            count_val[i]    = {1'b0, tv};
            expected_words.push_back(make_word(1'b0, 1'b0, SLOT_W'(i), '0, 1'b1));
          end
        end
        if (!found) expected_words.push_back(make_word(1'b1, 1'b0, '0, '0, 1'b1));
      end
      default: begin
        if (int'(sl) < TIMERS) begin
          case (fn)
            FN_DELETE: begin
              slot_used[sl]    = 1'b0;
              slot_running[sl] = 1'b0;
              slot_repeat[sl]  = 1'b0;
              reload_val[sl]   = '0;
              count_val[sl]    = '0;
            end
            FN_START: if (slot_used[sl]) slot_running[sl] = 1'b1;
            FN_STOP: if (slot_used[sl]) slot_running[sl] = 1'b0;
            FN_GET_TIME: begin
              expected_words.push_back(make_word(1'b0, 1'b0, '0, count_val[sl], 1'b1));
              get_done = 1'b1;
            end
            FN_SET_TIME: begin
              reload_val[sl] = {1'b0, tv};
              count_val[sl]  = {1'b0, tv};
            end
            FN_ONESHOT: slot_repeat[sl] = 1'b0;
            FN_PERIODIC: slot_repeat[sl] = 1'b1;
            default: ;
          endcase
        end
        if (!get_done) expected_words.push_back(make_word(1'b0, 1'b0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: result word %s mismatch: expected %0h, actual %0h",
               $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    timer_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        slot_used[i]    = 1'b0;
        slot_running[i] = 1'b0;
        slot_repeat[i]  = 1'b0;
        reload_val[i]   = '0;
        count_val[i]    = '0;
      end
      expected_words.delete();
      pending_words <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        advance_bank(req_mon.func, req_mon.slot, req_mon.time_value, req_mon.periodic_mode);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual st=%0d fi=%0d sl=%0d rem=%0h last=%0d",
                   $time, res_mon.status, res_mon.fired, res_mon.result_slot,
                   res_mon.remaining, res_mon.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(res_mon.status));
          check_field("fired", CNT_W'(want.fired), CNT_W'(res_mon.fired));
          check_field("result_slot", CNT_W'(want.slot), CNT_W'(res_mon.result_slot));
          check_field("remaining", want.remaining, res_mon.remaining);
          check_field("last", CNT_W'(want.last), CNT_W'(res_mon.last));
        end
      end
      pending_words <= expected_words.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the soft timer bank testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import stb_pkg::*;

  localparam int ITEMS_RANDOM    = 450;
  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int items_sent    = 0;
  bit pressure_done = 1'b0;
  bit sender_steady = 1'b0;
  int fail_count;
  int pending_words;
  int cycle_count   = 0;

  stb_in_if  req_ch ();
  stb_out_if res_ch ();

  soft_timer_bank_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  stb_result_checker result_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_ch),
    .res_mon       (res_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly short counts so timers actually fire.
  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return TIME_W'($urandom_range(0, 4));
    if (r < 75) return TIME_W'($urandom_range(5, 40));
    if (r < 90) return TIME_W'($urandom());
    if (r < 95) return {TIME_W{1'b1}};
    return TIME_W'(1);
  endfunction

  // Favor low slots, which create fills first.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 9) < 7) return SLOT_W'($urandom_range(0, 7));
    return SLOT_W'($urandom_range(0, 15));
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] sl,
                           input logic [TIME_W-1:0] tv, input logic pm);
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.func          <= fn;
    req_ch.slot          <= sl;
    req_ch.time_value    <= tv;
    req_ch.periodic_mode <= pm;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(FN_TICK, SLOT_W'($urandom()), TIME_W'($urandom()), 1'($urandom()));
  endtask

  // Create a timer, then arm and run a picked slot, with random extras around it.
  task automatic run_lifecycle();
    logic [SLOT_W-1:0] sl;
    sl = pick_slot();
    send_word(FN_CREATE, SLOT_W'($urandom()), pick_time(), 1'($urandom()));
    if ($urandom_range(0, 1) == 0) send_word(FN_SET_TIME, sl, pick_time(), 1'($urandom()));
    send_word(FN_START, sl, TIME_W'($urandom()), 1'($urandom()));
    repeat ($urandom_range(1, 4)) send_tick();
    if ($urandom_range(0, 1) == 0) send_word(FN_GET_TIME, sl, TIME_W'($urandom()), 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      send_word($urandom_range(0, 1) ? FN_PERIODIC : FN_ONESHOT, sl, pick_time(), 1'b1);
    end
    if ($urandom_range(0, 3) == 0) send_word(FN_STOP, sl, pick_time(), 1'b0);
  endtask

  // Receiver: random stalls in stretches, plus one long hold-off.
  initial begin
    int mode;
    res_ch.ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        res_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES - 1) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 9) < 7);
          default: begin
            if ($urandom_range(0, 49) == 0) begin
              res_ch.ready <= 1'b0;
              repeat ($urandom_range(10, 40) - 1) @(posedge clk);
            end else begin
              res_ch.ready <= ($urandom_range(0, 9) < 4);
            end
          end
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int directed_total;
    req_ch.valid         = 1'b0;
    req_ch.func          = FN_TICK;
    req_ch.slot          = '0;
    req_ch.time_value    = '0;
    req_ch.periodic_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // periodic count of one and one-shot count of zero fire on the first tick
    send_word(FN_CREATE, 4'd0, 31'd1, 1'b1);
    send_word(FN_CREATE, 4'd15, 31'd0, 1'b0);
    send_word(FN_START, 4'd0, '0, 1'b0);
    send_word(FN_START, 4'd1, '0, 1'b0);
    send_tick();
    send_word(FN_GET_TIME, 4'd1, '0, 1'b0);
    // restart a spent one-shot: it keeps counting below zero
    send_word(FN_START, 4'd1, '0, 1'b0);
    send_tick();
    send_word(FN_STOP, 4'd0, '0, 1'b0);
    send_word(FN_ONESHOT, 4'd0, '0, 1'b0);
    send_word(FN_PERIODIC, 4'd1, '0, 1'b1);
    // stored values of a free slot are still reachable
    send_word(FN_SET_TIME, 4'd15, {TIME_W{1'b1}}, 1'b1);
    send_word(FN_GET_TIME, 4'd15, '0, 1'b0);
    send_word(FN_START, 4'd15, '0, 1'b0);
    send_word(FN_STOP, 4'd15, '0, 1'b0);
    send_word(FN_DELETE, 4'd1, '0, 1'b0);
    send_word(FUNC_W'(9), 4'd3, 31'h5555_5555, 1'b1);
    send_word({FUNC_W{1'b1}}, 4'd15, {TIME_W{1'b1}}, 1'b1);
    // fill every slot, then one more create finds none free
    for (int i = 0; i < 16; i++) begin
      send_word(FN_CREATE, 4'd0, (i % 2) ? {TIME_W{1'b1}} : TIME_W'($urandom()), 1'(i));
    end
    directed_total = items_sent;

    while (items_sent < directed_total + ITEMS_RANDOM) begin
      if ($urandom_range(0, 9) == 0) sender_steady = ~sender_steady;
      case ($urandom_range(0, 9))
        0, 1, 2: run_lifecycle();
        3, 4: repeat ($urandom_range(2, 8)) send_tick();
        5: repeat ($urandom_range(3, 17)) begin
          send_word(FN_CREATE, SLOT_W'($urandom()), pick_time(), 1'($urandom()));
        end
        6: repeat ($urandom_range(1, 6)) begin
          send_word(FN_DELETE, pick_slot(), TIME_W'($urandom()), 1'($urandom()));
        end
        default: begin
          send_word(FUNC_W'($urandom_range(0, 15)), SLOT_W'($urandom()), pick_time(),
                    1'($urandom()));
        end
      endcase
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
